// ===== src/crcfr_pkg.sv =====
package crcfr_pkg;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_CRC_POLY      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_START_BYTE    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BYPASS_LABEL  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BYPASS_ENABLE = 2'd3;

  localparam logic [15:0] CRC_POLY_RST      = 16'h1021;
  localparam logic [7:0]  START_BYTE_RST    = 8'hff;
  localparam logic [15:0] BYPASS_LABEL_RST  = 16'hbadd;
  localparam logic        BYPASS_ENABLE_RST = 1'b1;

  // length byte counts cmd + payload; tag high byte sits at pos len+3, low at len+4
  localparam int unsigned TAG_HI_OFFSET = 3;
  localparam int unsigned TAG_LO_OFFSET = 4;
  localparam int unsigned PAYLOAD_FIRST = 4;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_GOOD   = 2'd1,
    EV_FORMAT = 2'd2,
    EV_CRC    = 2'd3
  } event_t;

  // MSB-first CRC16 of (hi << 8) under poly
  function automatic logic [15:0] crc_table_entry(input logic [7:0] hi,
                                                  input logic [15:0] poly);
    logic [15:0] t;
    t = {hi, 8'h00};
    for (int k = 0; k < 8; k++) begin
      t = t[15] ? ((t << 1) ^ poly) : (t << 1);
    end
    return t;
  endfunction

endpackage

// ===== src/crcfr_rx_if.sv =====
interface crcfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_value;

  modport source(output valid, output rx_value, input ready);
  modport sink(input valid, input rx_value, output ready);
endinterface

// ===== src/crcfr_res_if.sv =====
interface crcfr_res_if;
  logic              valid;
  logic              ready;
  crcfr_pkg::event_t event_res;
  logic [7:0]        frame_command;
  logic [7:0]        frame_length;
  logic              payload_valid;
  logic [7:0]        payload_index;
  logic [7:0]        payload_value;
  logic [31:0]       good_frames;
  logic [31:0]       format_errors;
  logic [31:0]       crc_errors;

  modport source(output valid, output event_res, output frame_command,
                 output frame_length, output payload_valid, output payload_index,
                 output payload_value, output good_frames, output format_errors,
                 output crc_errors, input ready);
  modport sink(input valid, input event_res, input frame_command,
               input frame_length, input payload_valid, input payload_index,
               input payload_value, input good_frames, input format_errors,
               input crc_errors, output ready);
endinterface

// ===== src/crc_checked_frame_receiver.sv =====
// Serial frame receiver with CRC16 check. Each rx beat carries one received byte
// and produces exactly one res beat: the frame verdict (none, good, format error,
// CRC error), the held command and length, the payload byte with its index when
// the byte is payload, and three wrapping frame counters. A new byte is taken
// every clock cycle while res is not stalled; each byte passes the input
// register, then the result register, with the combinational table CRC step
// and frame decode between them. The result register keeps a beat while res is
// stalled, and the input register can take one more byte. Configuration (polynomial,
// start byte, bypass label and enable) is written through wr_en/wr_index/wr_data;
// the user must do so only while no byte is in flight, which the block does not enforce.
module crc_checked_frame_receiver #(
  parameter int unsigned POSITION_WRAP = 512
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [crcfr_pkg::CFG_INDEX_W-1:0]   wr_index,
  input  logic [crcfr_pkg::CFG_DATA_W-1:0]    wr_data,
  crcfr_rx_if.sink                            rx,
  crcfr_res_if.source                         res
);
  import crcfr_pkg::*;

  localparam int unsigned PW = $clog2(POSITION_WRAP);
  localparam int unsigned CW = ((PW > 9) ? PW : 9) + 1;

  // configuration
  logic [15:0] crc_poly;
  logic [7:0]  start_byte;
  logic [15:0] bypass_label;
  logic        bypass_enable;

  // frame state
  logic [15:0]   crc_residue;
  logic          frame_open;
  logic [PW-1:0] byte_position;
  logic [7:0]    length_seen;
  logic [7:0]    command_seen;
  logic [15:0]   trailing_tag;
  logic [31:0]   good_count;
  logic [31:0]   format_count;
  logic [31:0]   crc_fail_count;

  // input stage
  logic       in_valid;
  logic [7:0] in_byte;

  logic advance;

  // next-state values
  logic [15:0]   crc_upd;
  logic [15:0]   crc_residue_next;
  logic          frame_open_next;
  logic [PW-1:0] pos_base;
  logic [PW:0]   pos_inc;
  logic [PW-1:0] byte_position_next;
  logic [7:0]    length_seen_next;
  logic [7:0]    command_seen_next;
  logic [15:0]   trailing_tag_next;
  logic [15:0]   tag_full;
  logic [31:0]   good_count_next;
  logic [31:0]   format_count_next;
  logic [31:0]   crc_fail_count_next;
  logic [CW-1:0] pos_w;
  logic [CW-1:0] tag_hi_pos;
  logic [CW-1:0] tag_lo_pos;
  event_t        ev;
  logic          pvalid;
  logic [7:0]    pindex;
  logic [7:0]    pvalue;

  assign advance  = in_valid && (!res.valid || res.ready);
  assign rx.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_poly      <= CRC_POLY_RST;
      start_byte    <= START_BYTE_RST;
      bypass_label  <= BYPASS_LABEL_RST;
      bypass_enable <= BYPASS_ENABLE_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_CRC_POLY:      crc_poly      <= wr_data;
        REG_START_BYTE:    start_byte    <= wr_data[7:0];
        REG_BYPASS_LABEL:  bypass_label  <= wr_data;
        REG_BYPASS_ENABLE: bypass_enable <= wr_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    crc_upd    = {crc_residue[7:0], in_byte} ^ crc_table_entry(crc_residue[15:8], crc_poly);
    pos_w      = CW'(byte_position);
    tag_hi_pos = CW'(length_seen) + CW'(TAG_HI_OFFSET);
    tag_lo_pos = CW'(length_seen) + CW'(TAG_LO_OFFSET);
    tag_full   = trailing_tag | {8'h00, in_byte};

    crc_residue_next  = crc_upd;
    frame_open_next   = frame_open;
    pos_base          = byte_position;
    length_seen_next  = length_seen;
    command_seen_next = command_seen;
    trailing_tag_next = trailing_tag;
    ev                = EV_NONE;
    pvalid            = 1'b0;
    pindex            = 8'h00;
    pvalue            = 8'h00;

    if (!frame_open && in_byte == start_byte) begin
      frame_open_next   = 1'b1;
      crc_residue_next  = {8'h00, in_byte};
      trailing_tag_next = 16'h0000;
      pos_base          = '0;
    end else if (pos_w == CW'(1)) begin
      if (in_byte != 8'h00) ev = EV_FORMAT;
    end else if (pos_w == CW'(2)) begin
      if (in_byte == 8'h00) ev = EV_FORMAT;
      length_seen_next = in_byte;
    end else if (pos_w == CW'(3)) begin
      command_seen_next = in_byte;
    end else if (pos_w > CW'(3) && pos_w < tag_hi_pos) begin
      pvalid = 1'b1;
      pindex = 8'(pos_w - CW'(PAYLOAD_FIRST));
      pvalue = in_byte;
    end else if (pos_w == tag_hi_pos) begin
      trailing_tag_next = {in_byte, 8'h00};
    end else if (pos_w == tag_lo_pos) begin
      trailing_tag_next = tag_full;
      if (crc_upd == 16'h0000 || (bypass_enable && tag_full == bypass_label)) begin
        ev = EV_GOOD;
      end else begin
        ev = EV_CRC;
      end
    end else begin
      ev = EV_FORMAT;
    end

    // frame end or abort; a zero length byte also lands here with length 0
    if (ev != EV_NONE) begin
      frame_open_next  = 1'b0;
      pos_base         = '0;
      length_seen_next = 8'h00;
    end

    pos_inc = {1'b0, pos_base} + (PW+1)'(1);
    byte_position_next = (pos_inc >= (PW+1)'(POSITION_WRAP)) ? '0 : pos_inc[PW-1:0];

    good_count_next     = good_count     + 32'(ev == EV_GOOD);
    format_count_next   = format_count   + 32'(ev == EV_FORMAT);
    crc_fail_count_next = crc_fail_count + 32'(ev == EV_CRC);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid       <= 1'b0;
      res.valid      <= 1'b0;
      crc_residue    <= 16'h0000;
      frame_open     <= 1'b0;
      byte_position  <= '0;
      length_seen    <= 8'h00;
      command_seen   <= 8'h00;
      trailing_tag   <= 16'h0000;
      good_count     <= 32'h0;
      format_count   <= 32'h0;
      crc_fail_count <= 32'h0;
    end else begin
      if (rx.ready) begin
        in_valid <= rx.valid;
      end
      if (advance) begin
        res.valid      <= 1'b1;
        crc_residue    <= crc_residue_next;
        frame_open     <= frame_open_next;
        byte_position  <= byte_position_next;
        length_seen    <= length_seen_next;
        command_seen   <= command_seen_next;
        trailing_tag   <= trailing_tag_next;
        good_count     <= good_count_next;
        format_count   <= format_count_next;
        crc_fail_count <= crc_fail_count_next;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      in_byte <= rx.rx_value;
    end
    if (advance) begin
      res.event_res     <= ev;
      res.frame_command <= command_seen_next;
      res.frame_length  <= length_seen_next;
      res.payload_valid <= pvalid;
      res.payload_index <= pindex;
      res.payload_value <= pvalue;
      res.good_frames   <= good_count_next;
      res.format_errors <= format_count_next;
      res.crc_errors    <= crc_fail_count_next;
    end
  end

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    CW'(byte_position) < CW'(POSITION_WRAP))
    else $error("byte position reached wrap value");

  a_end_closes_frame: assert property (@(posedge clk) disable iff (rst)
    advance && ev != EV_NONE |=> !frame_open && byte_position == PW'(1) && length_seen == 8'h00)
    else $error("frame not closed after verdict");

  a_good_counts: assert property (@(posedge clk) disable iff (rst)
    advance && ev == EV_GOOD |=> good_count == $past(good_count) + 32'd1
                                 && format_count == $past(format_count))
    else $error("good frame counter out of step");

  a_payload_no_verdict: assert property (@(posedge clk) disable iff (rst)
    advance && pvalid |-> ev == EV_NONE && frame_open == frame_open_next)
    else $error("payload byte carried a verdict");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_byte))
    else $error("stalled input byte lost");

endmodule
